/* rtl/pexalu_pkg.sv */
// Shared types and codes for the pipelined execute stage ALU.
package pexalu_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned REG_W  = 4;
    localparam int unsigned OP_W   = 4;
    localparam int unsigned FN_W   = 4;
    localparam int unsigned STAT_W = 2;

    localparam logic [OP_W-1:0] OP_HALT  = 4'd0;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd1;
    localparam logic [OP_W-1:0] OP_CMOV  = 4'd2;
    localparam logic [OP_W-1:0] OP_IRMOV = 4'd3;
    localparam logic [OP_W-1:0] OP_RMMOV = 4'd4;
    localparam logic [OP_W-1:0] OP_MRMOV = 4'd5;
    localparam logic [OP_W-1:0] OP_ALU   = 4'd6;
    localparam logic [OP_W-1:0] OP_JUMP  = 4'd7;
    localparam logic [OP_W-1:0] OP_CALL  = 4'd8;
    localparam logic [OP_W-1:0] OP_RET   = 4'd9;
    localparam logic [OP_W-1:0] OP_PUSH  = 4'd10;
    localparam logic [OP_W-1:0] OP_POP   = 4'd11;
    localparam logic [OP_W-1:0] OP_DUMP  = 4'd12;

    localparam logic [FN_W-1:0] FN_ADD = 4'd0;
    localparam logic [FN_W-1:0] FN_SUB = 4'd1;
    localparam logic [FN_W-1:0] FN_AND = 4'd2;
    localparam logic [FN_W-1:0] FN_XOR = 4'd3;

    localparam logic [FN_W-1:0] CND_ALWAYS = 4'd0;
    localparam logic [FN_W-1:0] CND_LE     = 4'd1;
    localparam logic [FN_W-1:0] CND_L      = 4'd2;
    localparam logic [FN_W-1:0] CND_E      = 4'd3;
    localparam logic [FN_W-1:0] CND_NE     = 4'd4;
    localparam logic [FN_W-1:0] CND_GE     = 4'd5;
    localparam logic [FN_W-1:0] CND_G      = 4'd6;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_HALT = 2'd1;
    localparam logic [STAT_W-1:0] ST_ADR  = 2'd2;
    localparam logic [STAT_W-1:0] ST_INS  = 2'd3;

    localparam logic [REG_W-1:0]  REG_NONE   = 4'd15;
    localparam logic [WORD_W-1:0] STACK_STEP = 32'd4;

    typedef struct packed {
        logic [STAT_W-1:0] in_status;
        logic [OP_W-1:0]   opcode;
        logic [FN_W-1:0]   func_code;
        logic [WORD_W-1:0] const_value;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [REG_W-1:0]  dest_e_in;
        logic [REG_W-1:0]  dest_m_in;
        logic [STAT_W-1:0] mem_stage_status;
        logic [STAT_W-1:0] wb_stage_status;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] out_status;
        logic [OP_W-1:0]   out_opcode;
        logic              cond_ok;
        logic [WORD_W-1:0] alu_value;
        logic [WORD_W-1:0] pass_a;
        logic [REG_W-1:0]  dest_e_out;
        logic [REG_W-1:0]  dest_m_out;
    } out_item_t;

    typedef struct packed {
        logic zf;
        logic sf;
        logic of;
    } flags_t;

endpackage

/* rtl/pexalu_in_if.sv */
// Valid/ready channel that carries one decoded instruction item.
interface pexalu_in_if import pexalu_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/pexalu_out_if.sv */
// Valid/ready channel that carries one execute result item.
interface pexalu_out_if import pexalu_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/pexalu_core.sv */
// Combinational execute logic: ALU, condition evaluation, flag update and bubbling.
module pexalu_core import pexalu_pkg::*; (
    input  in_item_t  item,
    input  flags_t    flags,
    output out_item_t result,
    output flags_t    flags_next
);

    logic              lt;
    logic              cnd;
    logic [WORD_W-1:0] val;
    logic [WORD_W-1:0] sum_ab;
    logic [WORD_W-1:0] diff_ba;
    logic [STAT_W-1:0] st;
    logic              alu_good;
    logic              ovf;
    logic              fault;

    assign lt      = flags.sf ^ flags.of;
    assign sum_ab  = item.operand_b + item.operand_a;
    assign diff_ba = item.operand_b - item.operand_a;
    assign fault   = (item.mem_stage_status != ST_OK) || (item.wb_stage_status != ST_OK);

    always_comb
    begin
        cnd = 1'b0;
        if (item.opcode == OP_CMOV || item.opcode == OP_JUMP)
        begin
            case (item.func_code)
                CND_ALWAYS: cnd = 1'b1;
                CND_LE:     cnd = lt | flags.zf;
                CND_L:      cnd = lt;
                CND_E:      cnd = flags.zf;
                CND_NE:     cnd = ~flags.zf;
                CND_GE:     cnd = ~lt;
                CND_G:      cnd = ~lt & ~flags.zf;
                default:    cnd = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        val      = '0;
        st       = item.in_status;
        alu_good = 1'b0;
        ovf      = 1'b0;
        if (item.in_status != ST_INS)
        begin
            case (item.opcode)
                OP_CMOV:                   val = item.operand_a;
                OP_IRMOV, OP_JUMP, OP_DUMP: val = item.const_value;
                OP_RMMOV, OP_MRMOV:        val = item.operand_b + item.const_value;
                OP_CALL, OP_PUSH:          val = item.operand_b - STACK_STEP;
                OP_RET, OP_POP:            val = item.operand_b + STACK_STEP;
                OP_ALU:
                begin
                    alu_good = 1'b1;
                    case (item.func_code)
                        FN_ADD:
                        begin
                            val = sum_ab;
                            ovf = (item.operand_a[WORD_W-1] == item.operand_b[WORD_W-1])
                                && (sum_ab[WORD_W-1] != item.operand_a[WORD_W-1]);
                        end
                        FN_SUB:
                        begin
                            val = diff_ba;
                            ovf = (item.operand_a[WORD_W-1] != item.operand_b[WORD_W-1])
                                && (diff_ba[WORD_W-1] == item.operand_a[WORD_W-1]);
                        end
                        FN_AND: val = item.operand_b & item.operand_a;
                        FN_XOR: val = item.operand_b ^ item.operand_a;
                        default:
                        begin
                            alu_good = 1'b0;
                            st       = ST_INS;
                        end
                    endcase
                end
                default: val = '0;
            endcase
        end
    end

    always_comb
    begin
        flags_next = flags;
        if (alu_good)
        begin
            flags_next.zf = (val == '0);
            flags_next.sf = val[WORD_W-1];
            flags_next.of = ovf;
        end
        // A fault further down the pipe squashes this instruction and clears the flags.
        if (fault)
        begin
            flags_next = '0;
        end
    end

    always_comb
    begin
        if (fault)
        begin
            result.out_status = ST_OK;
            result.out_opcode = OP_NOP;
            result.cond_ok    = 1'b0;
            result.alu_value  = '0;
            result.pass_a     = '0;
            result.dest_e_out = REG_NONE;
            result.dest_m_out = REG_NONE;
        end
        else
        begin
            result.out_status = st;
            result.out_opcode = item.opcode;
            result.cond_ok    = cnd;
            result.alu_value  = val;
            result.pass_a     = item.operand_a;
            result.dest_e_out = (item.opcode == OP_CMOV && !cnd) ? REG_NONE : item.dest_e_in;
            result.dest_m_out = item.dest_m_in;
        end
    end

endmodule

/* rtl/pipelined_execute_stage_alu.sv */
// Execute stage: input register, execute logic and result register with condition flags.
// An accepted item is held in the input register, executed, and presented from the result register.
// Throughput: one item per cycle while results are taken; a held result still lets an empty input register refill.
// The flags are written when an item moves into the result register, so the next item
// to execute sees them with no gap.
// Reset clears both valid bits and the three flags; payload registers are not reset.
module pipelined_execute_stage_alu import pexalu_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    pexalu_in_if.sink    req,
    pexalu_out_if.source rsp
);

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    flags_t    flags_reg;
    flags_t    flags_next;
    out_item_t result;
    logic      advance;
    logic      take;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    pexalu_core u_core (
        .item       (in_reg),
        .flags      (flags_reg),
        .result     (result),
        .flags_next (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= req.data;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    a_fault_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_reg.mem_stage_status != ST_OK || in_reg.wb_stage_status != ST_OK)
        |=> flags_reg == '0)
        else $error("flags not cleared after a downstream fault");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("flags changed with no item executing");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("executed item did not reach the result register");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("input stalled while the result register is empty");

    a_failed_cmov: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rsp.data.out_opcode == OP_CMOV && !rsp.data.cond_ok
        |-> rsp.data.dest_e_out == REG_NONE)
        else $error("failed conditional move kept its destination");

endmodule
